FILE: design/cmds_pkg.sv
// shared types, constants and the code load function of the coded motor direction sequencer
`timescale 1ns / 1ps

package cmds_pkg;

   localparam int HALF_SECOND_TICKS = 100;
   localparam int CODE_BYTES = 3;
   localparam int CODE_BITS = 8 * CODE_BYTES;
   localparam int BIT_CNT_W = $clog2(CODE_BITS + 1);
   localparam int TICK_W = $clog2(3 * HALF_SECOND_TICKS + 1);
   localparam int CFG_REGS = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HEADER  = 2'd0,
      REG_ADDRESS = 2'd1,
      REG_MODE    = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      KIND_TICK      = 2'd0,
      KIND_CLOCKWISE = 2'd1,
      KIND_ANTICLOCK = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_CODE_LOW    = 3'd1,
      PH_CODE_HIGH   = 3'd2,
      PH_DRIVE       = 3'd3,
      PH_DRIVE_EXTRA = 3'd4
   } phase_type;

   typedef logic [CFG_REGS-1:0][CSR_DATA_W-1:0] cfg_bytes_type;

   typedef struct packed {
      phase_type              phase;
      logic [CODE_BITS-1:0]   code_shift;
      logic [BIT_CNT_W-1:0]   bit_count;
      logic [TICK_W-1:0]      tick_count;
      logic                   clockwise_run;
      logic                   lock_flag;
      logic                   coil_one;
      logic                   coil_two;
   } seq_state_type;

   typedef struct packed {
      logic coil_one;
      logic coil_two;
      logic lock;
      logic busy_res;
      logic rejected;
   } result_type;

   localparam seq_state_type STATE_RESET = '{
      phase:         PH_IDLE,
      code_shift:    '0,
      bit_count:     '0,
      tick_count:    '0,
      clockwise_run: 1'b0,
      lock_flag:     1'b0,
      coil_one:      1'b1,
      coil_two:      1'b1
   };

   // header byte goes out first, bytes past the register set are zero
   function automatic logic [CODE_BITS-1:0] code_load(input cfg_bytes_type cfg);
      logic [CODE_BITS-1:0] code;
      logic [7:0]           b;
      code = '0;
      for (int k = 0; k < CODE_BYTES; k++) begin
         b = '0;
         if (k < CFG_REGS) begin
            b = cfg[k];
         end
         code[CODE_BITS-1-8*k -: 8] = b;
      end
      return code;
   endfunction

endpackage

FILE: design/cmds_csr.sv
// configuration register file holding the coded preamble bytes
`timescale 1ns / 1ps

module cmds_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [cmds_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cmds_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output cmds_pkg::cfg_bytes_type             cfg_bytes
);

   cmds_pkg::cfg_bytes_type cfg_bytes_ff;
   cmds_pkg::cfg_bytes_type cfg_bytes_in;

   always_comb begin
      cfg_bytes_in = cfg_bytes_ff;
      if (csr_we) begin
         case (csr_index)
            cmds_pkg::REG_HEADER:  cfg_bytes_in[0] = csr_wdata;
            cmds_pkg::REG_ADDRESS: cfg_bytes_in[1] = csr_wdata;
            cmds_pkg::REG_MODE:    cfg_bytes_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_bytes_ff <= '0;
      end else begin
         cfg_bytes_ff <= cfg_bytes_in;
      end
   end

   assign cfg_bytes = cfg_bytes_ff;

endmodule

FILE: design/cmds_step.sv
// next-state and result logic for one item of the sequencer
`timescale 1ns / 1ps

module cmds_step (
   input  cmds_pkg::seq_state_type  state,
   input  logic [1:0]               kind,
   input  logic                     overcurrent,
   input  cmds_pkg::cfg_bytes_type  cfg_bytes,
   output cmds_pkg::seq_state_type  state_next,
   output cmds_pkg::result_type     result
);

   always_comb begin
      cmds_pkg::seq_state_type s;
      logic                    rej;
      s = state;
      rej = 1'b0;
      case (kind)
         cmds_pkg::KIND_TICK: begin
            if (s.phase != cmds_pkg::PH_IDLE) begin
               if (s.tick_count != '0) begin
                  s.tick_count = s.tick_count - cmds_pkg::TICK_W'(1);
               end
               if (s.tick_count == '0) begin
                  case (s.phase)
                     cmds_pkg::PH_CODE_LOW: begin
                        s.coil_two = 1'b1;
                        s.tick_count = cmds_pkg::TICK_W'(1);
                        s.phase = cmds_pkg::PH_CODE_HIGH;
                     end
                     cmds_pkg::PH_CODE_HIGH: begin
                        s.code_shift = {s.code_shift[cmds_pkg::CODE_BITS-2:0], 1'b0};
                        if (s.bit_count != '0) begin
                           s.bit_count = s.bit_count - cmds_pkg::BIT_CNT_W'(1);
                        end
                        if (s.bit_count != '0) begin
                           s.coil_two = 1'b0;
                           s.tick_count = s.code_shift[cmds_pkg::CODE_BITS-1] ?
                                          cmds_pkg::TICK_W'(2) : cmds_pkg::TICK_W'(1);
                           s.phase = cmds_pkg::PH_CODE_LOW;
                        end else begin
                           s.coil_one = 1'b1;
                           s.coil_two = 1'b0;
                           s.tick_count = cmds_pkg::TICK_W'(2 * cmds_pkg::HALF_SECOND_TICKS);
                           s.phase = cmds_pkg::PH_DRIVE;
                        end
                     end
                     cmds_pkg::PH_DRIVE: begin
                        if (!overcurrent) begin
                           s.tick_count =
                              cmds_pkg::TICK_W'(3 * cmds_pkg::HALF_SECOND_TICKS);
                           s.phase = cmds_pkg::PH_DRIVE_EXTRA;
                        end else begin
                           s.coil_one = 1'b1;
                           s.coil_two = 1'b1;
                           if (s.clockwise_run) begin
                              s.lock_flag = 1'b0;
                           end
                           s.phase = cmds_pkg::PH_IDLE;
                        end
                     end
                     default: begin
                        s.coil_one = 1'b1;
                        s.coil_two = 1'b1;
                        if (s.clockwise_run) begin
                           s.lock_flag = 1'b0;
                        end
                        s.phase = cmds_pkg::PH_IDLE;
                     end
                  endcase
               end
            end
         end
         cmds_pkg::KIND_CLOCKWISE: begin
            if (s.phase != cmds_pkg::PH_IDLE) begin
               rej = 1'b1;
            end else begin
               s.clockwise_run = 1'b1;
               s.code_shift = cmds_pkg::code_load(cfg_bytes);
               s.bit_count = cmds_pkg::BIT_CNT_W'(cmds_pkg::CODE_BITS);
               s.coil_two = 1'b0;
               s.tick_count = s.code_shift[cmds_pkg::CODE_BITS-1] ?
                              cmds_pkg::TICK_W'(2) : cmds_pkg::TICK_W'(1);
               s.phase = cmds_pkg::PH_CODE_LOW;
            end
         end
         cmds_pkg::KIND_ANTICLOCK: begin
            if (s.phase != cmds_pkg::PH_IDLE) begin
               rej = 1'b1;
            end else begin
               s.clockwise_run = 1'b0;
               s.lock_flag = 1'b1;
               s.coil_one = 1'b0;
               s.coil_two = 1'b1;
               s.tick_count = cmds_pkg::TICK_W'(2 * cmds_pkg::HALF_SECOND_TICKS);
               s.phase = cmds_pkg::PH_DRIVE;
            end
         end
         default: ;
      endcase
      state_next = s;
      result.coil_one = s.coil_one;
      result.coil_two = s.coil_two;
      result.lock = s.lock_flag;
      result.busy_res = (s.phase != cmds_pkg::PH_IDLE);
      result.rejected = rej;
   end

endmodule

FILE: design/coded_motor_direction_sequencer.sv
// top level of the coded motor direction sequencer
`timescale 1ns / 1ps
// usage
//  req channel carries one item per handshake: kind (tick, clockwise or
//  anticlockwise start) and the overcurrent level. rsp channel returns one
//  item per request with the coil levels, lock flag, busy and rejected bits.
//  csr port writes the header, address and mode bytes; write only while idle.
//  an item is taken when valid is high and stall is low on a rising edge.
//  the request waits in the input register until the result register is
//  free, then its result is computed, registered there and offered.
//  throughput: one item per cycle unless the receiver stalls; the state
//  update is a single pass of small logic between the two registers.
//  when the receiver stalls, the result register holds and the input
//  register can still take one more item; further requests are stalled.
//  reset (synchronous, active high) empties both registers, clears the
//  csr bytes to zero, returns to idle with both coils high and lock clear.

module coded_motor_direction_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_kind,
   input  logic                               req_overcurrent,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_coil_one,
   output logic                               rsp_coil_two,
   output logic                               rsp_lock,
   output logic                               rsp_busy_res,
   output logic                               rsp_rejected,
   input  logic                               csr_we,
   input  logic [cmds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cmds_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   cmds_pkg::cfg_bytes_type  cfg_bytes;
   cmds_pkg::seq_state_type  state_ff;
   cmds_pkg::seq_state_type  state_in;
   cmds_pkg::result_type     result_ff;
   cmds_pkg::result_type     result_in;
   logic                     in_valid_ff;
   logic                     in_valid_in;
   logic [1:0]               in_kind_ff;
   logic                     in_oc_ff;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   logic                     out_ready;
   logic                     advance;
   logic                     accept;

   cmds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_bytes (cfg_bytes)
   );

   cmds_step u_step (
      .state       (state_ff),
      .kind        (in_kind_ff),
      .overcurrent (in_oc_ff),
      .cfg_bytes   (cfg_bytes),
      .state_next  (state_in),
      .result      (result_in)
   );

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= cmds_pkg::STATE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff <= req_kind;
         in_oc_ff <= req_overcurrent;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_coil_one = result_ff.coil_one;
   assign rsp_coil_two = result_ff.coil_two;
   assign rsp_lock = result_ff.lock;
   assign rsp_busy_res = result_ff.busy_res;
   assign rsp_rejected = result_ff.rejected;

endmodule

FILE: design/cmds_checker.sv
// port-level checker for the sequencer and its bind to the top level
`timescale 1ns / 1ps

module cmds_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_coil_one,
   input logic rsp_coil_two,
   input logic rsp_lock,
   input logic rsp_busy_res,
   input logic rsp_rejected
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_coil_one) &&
      $stable(rsp_coil_two) && $stable(rsp_lock) && $stable(rsp_busy_res) &&
      $stable(rsp_rejected))
      else $error("result item changed while stalled");

   // a refused command only happens during a sequence
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_busy_res)
      else $error("command rejected while idle");

   // idle leaves both coils high
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_coil_one && rsp_coil_two)
      else $error("coil low while idle");

   // coil one low only in the anticlockwise drive, which holds the lock
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_coil_one |-> rsp_lock && rsp_coil_two && rsp_busy_res)
      else $error("coil one low outside anticlockwise drive");

endmodule

bind coded_motor_direction_sequencer cmds_checker u_cmds_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_coil_one (rsp_coil_one),
   .rsp_coil_two (rsp_coil_two),
   .rsp_lock     (rsp_lock),
   .rsp_busy_res (rsp_busy_res),
   .rsp_rejected (rsp_rejected)
);

FILE: bench/tb_top.sv
// self-checking testbench of the coded motor direction sequencer
`timescale 1ns / 1ps

module tb_top;
   import cmds_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int PHASE_ITEMS = 200;
   localparam int LONG_HOLD = 60;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic       oc;
      logic [9:0] reps;
      logic       typed;
      result_type lv;
   } plan_row_type;

   // levels are coil_one, coil_two, lock, busy_res, rejected
   localparam plan_row_type PLAN [17] = '{
      '{KIND_TICK,      1'b0, 10'd1,   1'b1, 5'b11000},
      '{KIND_SPARE,     1'b1, 10'd1,   1'b1, 5'b11000},
      '{KIND_ANTICLOCK, 1'b0, 10'd1,   1'b1, 5'b01110},
      '{KIND_CLOCKWISE, 1'b1, 10'd1,   1'b1, 5'b01111},
      '{KIND_ANTICLOCK, 1'b0, 10'd1,   1'b1, 5'b01111},
      '{KIND_TICK,      1'b0, 10'd198, 1'b0, 5'b00000},
      '{KIND_SPARE,     1'b0, 10'd1,   1'b0, 5'b00000},
      '{KIND_TICK,      1'b1, 10'd1,   1'b0, 5'b00000},
      '{KIND_TICK,      1'b1, 10'd1,   1'b1, 5'b11100},
      '{KIND_TICK,      1'b0, 10'd1,   1'b1, 5'b11100},
      '{KIND_CLOCKWISE, 1'b0, 10'd1,   1'b1, 5'b10110},
      '{KIND_TICK,      1'b1, 10'd1,   1'b0, 5'b00000},
      '{KIND_ANTICLOCK, 1'b1, 10'd1,   1'b1, 5'b11111},
      '{KIND_TICK,      1'b1, 10'd246, 1'b0, 5'b00000},
      '{KIND_TICK,      1'b0, 10'd1,   1'b1, 5'b10110},
      '{KIND_TICK,      1'b1, 10'd299, 1'b0, 5'b00000},
      '{KIND_TICK,      1'b1, 10'd1,   1'b1, 5'b11000}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_kind = KIND_TICK;
   logic                  req_overcurrent = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_coil_one;
   logic                  rsp_coil_two;
   logic                  rsp_lock;
   logic                  rsp_busy_res;
   logic                  rsp_rejected;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_HEADER;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   coded_motor_direction_sequencer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_overcurrent (req_overcurrent),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_coil_one    (rsp_coil_one),
      .rsp_coil_two    (rsp_coil_two),
      .rsp_lock        (rsp_lock),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_rejected    (rsp_rejected),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

   // predicted sequencer state and code bytes
   phase_type            seq_phase;
   logic [CODE_BITS-1:0] code_bits;
   logic [BIT_CNT_W-1:0] bits_left;
   logic [TICK_W-1:0]    ticks_left;
   logic                 cw_run;
   logic                 lock_on;
   logic                 lvl_one;
   logic                 lvl_two;
   logic [7:0]           hdr_byte;
   logic [7:0]           adr_byte;
   logic [7:0]           mde_byte;

   result_type pending_levels [$];
   int         fault_count = 0;
   bit         offer_typed = 1'b0;
   result_type offer_lv = '0;
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   bit         hold_request = 1'b0;
   int         hold_left = 0;
   int         random_items = 0;

   task automatic start_code_bit();
      lvl_two = 1'b0;
      ticks_left = code_bits[CODE_BITS-1] ? TICK_W'(2) : TICK_W'(1);
      seq_phase = PH_CODE_LOW;
   endtask

   task automatic start_drive(input logic one, input logic two);
      lvl_one = one;
      lvl_two = two;
      ticks_left = TICK_W'(2 * HALF_SECOND_TICKS);
      seq_phase = PH_DRIVE;
   endtask

   task automatic end_run();
      lvl_one = 1'b1;
      lvl_two = 1'b1;
      if (cw_run) begin
         lock_on = 1'b0;
      end
      seq_phase = PH_IDLE;
   endtask

   task automatic step_sequencer(input logic [1:0] kind, input logic oc,
                                 output result_type lv);
      logic [7:0] b;
      logic       rej;
      rej = 1'b0;
      if (kind == KIND_TICK) begin
         if (seq_phase != PH_IDLE) begin
            if (ticks_left != '0) begin
               ticks_left = ticks_left - TICK_W'(1);
            end
            if (ticks_left == '0) begin
               case (seq_phase)
                  PH_CODE_LOW: begin
                     lvl_two = 1'b1;
                     ticks_left = TICK_W'(1);
                     seq_phase = PH_CODE_HIGH;
                  end
                  PH_CODE_HIGH: begin
                     code_bits = code_bits << 1;
                     if (bits_left != '0) begin
                        bits_left = bits_left - BIT_CNT_W'(1);
                     end
                     if (bits_left != '0) begin
                        start_code_bit();
                     end else begin
                        start_drive(1'b1, 1'b0);
                     end
                  end
                  PH_DRIVE: begin
                     if (!oc) begin
                        ticks_left = TICK_W'(3 * HALF_SECOND_TICKS);
                        seq_phase = PH_DRIVE_EXTRA;
                     end else begin
                        end_run();
                     end
                  end
                  default: end_run();
               endcase
            end
         end
      end else if (kind == KIND_CLOCKWISE || kind == KIND_ANTICLOCK) begin
         if (seq_phase != PH_IDLE) begin
            rej = 1'b1;
         end else if (kind == KIND_CLOCKWISE) begin
            cw_run = 1'b1;
            code_bits = '0;
            for (int k = 0; k < CODE_BYTES; k++) begin
               b = (k == 0) ? hdr_byte : (k == 1) ? adr_byte : (k == 2) ? mde_byte : 8'h00;
               code_bits = (code_bits << 8) | CODE_BITS'(b);
            end
            bits_left = BIT_CNT_W'(CODE_BITS);
            start_code_bit();
         end else begin
            cw_run = 1'b0;
            lock_on = 1'b1;
            start_drive(1'b0, 1'b1);
         end
      end
      lv.coil_one = lvl_one;
      lv.coil_two = lvl_two;
      lv.lock = lock_on;
      lv.busy_res = (seq_phase != PH_IDLE);
      lv.rejected = rej;
   endtask

   always @(posedge clock) begin
      result_type lv;
      result_type want;
      if (reset) begin
         seq_phase = PH_IDLE;
         code_bits = '0;
         bits_left = '0;
         ticks_left = '0;
         cw_run = 1'b0;
         lock_on = 1'b0;
         lvl_one = 1'b1;
         lvl_two = 1'b1;
         hdr_byte = '0;
         adr_byte = '0;
         mde_byte = '0;
         pending_levels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_HEADER:  hdr_byte = csr_wdata;
               REG_ADDRESS: adr_byte = csr_wdata;
               REG_MODE:    mde_byte = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_levels.size() == 0) begin
               $error("result item with no expectation pending");
               fault_count++;
            end else begin
               want = pending_levels.pop_front();
               if (rsp_coil_one !== want.coil_one) begin
                  $error("coil_one expected %0d got %0d", want.coil_one, rsp_coil_one);
                  fault_count++;
               end
               if (rsp_coil_two !== want.coil_two) begin
                  $error("coil_two expected %0d got %0d", want.coil_two, rsp_coil_two);
                  fault_count++;
               end
               if (rsp_lock !== want.lock) begin
                  $error("lock expected %0d got %0d", want.lock, rsp_lock);
                  fault_count++;
               end
               if (rsp_busy_res !== want.busy_res) begin
                  $error("busy_res expected %0d got %0d", want.busy_res, rsp_busy_res);
                  fault_count++;
               end
               if (rsp_rejected !== want.rejected) begin
                  $error("rejected expected %0d got %0d", want.rejected, rsp_rejected);
                  fault_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            step_sequencer(req_kind, req_overcurrent, lv);
            pending_levels.push_back(offer_typed ? offer_lv : lv);
         end
      end
   end

   // receiver stalls, with a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic put_item(input logic [1:0] kind, input logic oc, input bit typed,
                           input result_type lv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_overcurrent <= oc;
      offer_typed = typed;
      offer_lv = lv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_levels.size() != 0) @(negedge clock);
   endtask

   task automatic load_code_bytes(input logic [7:0] hdr, input logic [7:0] adr,
                                  input logic [7:0] mde);
      csr_we <= 1'b1;
      csr_index <= REG_HEADER;
      csr_wdata <= hdr;
      @(negedge clock);
      csr_index <= REG_ADDRESS;
      csr_wdata <= adr;
      @(negedge clock);
      csr_index <= REG_MODE;
      csr_wdata <= mde;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // idling phase follows the count of random items sent so far
   task automatic pick_idling();
      case ((random_items / PHASE_ITEMS) % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 60; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 60; end
         default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
   endtask

   task automatic run_motor_cycle();
      int         lead;
      int         sent;
      int         r;
      logic [1:0] noise;
      lead = $urandom_range(3);
      repeat (lead) begin
         pick_idling();
         put_item(KIND_TICK, 1'($urandom_range(1)), 1'b0, '0);
         random_items++;
      end
      pick_idling();
      put_item($urandom_range(1) ? KIND_CLOCKWISE : KIND_ANTICLOCK, 1'($urandom_range(1)),
               1'b0, '0);
      random_items++;
      sent = 0;
      while (seq_phase != PH_IDLE) begin
         r = $urandom_range(99);
         if (sent == 20) begin
            hold_request = 1'b1;
         end
         pick_idling();
         if (r < 4) begin
            noise = (r == 3) ? KIND_SPARE : 2'($urandom_range(2));
            put_item(noise, 1'($urandom_range(1)), 1'b0, '0);
            if (noise != KIND_SPARE) begin
               random_items++;
            end
         end else begin
            put_item(KIND_TICK, 1'($urandom_range(1)), 1'b0, '0);
            random_items++;
         end
         sent++;
      end
   endtask

   initial begin
      int cycle_no;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (PLAN[i]) begin
         repeat (PLAN[i].reps) begin
            put_item(PLAN[i].kind, PLAN[i].oc, PLAN[i].typed, PLAN[i].lv);
         end
      end

      cycle_no = 0;
      while (random_items < RANDOM_ITEMS) begin
         drain_results();
         case (cycle_no)
            0:       load_code_bytes(8'hFF, 8'hFF, 8'hFF);
            1:       load_code_bytes(8'h80, 8'h00, 8'h01);
            default: load_code_bytes(8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         run_motor_cycle();
         cycle_no++;
      end

      drain_results();
      repeat (10) @(negedge clock);
      if (fault_count == 0 && pending_levels.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
